### rtl/ledmx_pkg.sv
// Shared types and constants for the LED matrix frame encoder.
// Used by ledmx_scale, rgb_led_matrix_frame_encoder and the testbench. It depends on nothing else.
`timescale 1ns / 1ps

package ledmx_pkg;

  // Pixel store geometry. The store is always 64 deep; the active matrix uses its lowest entries.
  localparam int PixDepth    = 64;
  localparam int PixIdxW     = 6;
  localparam int DefaultRows = 8;
  localparam int DefaultCols = 8;
  localparam int CoordW      = 3;

  // Widths of the colour and brightness paths.
  localparam int ChanW   = 8;
  localparam int ColorW  = 3 * ChanW;
  localparam int LevelW  = 7;
  localparam int ProdW   = ChanW + LevelW;

  // floor(p / 100) equals (p * 5243) >> 19 for every p below 43690, and p needs only 15 bits.
  localparam int RecipMul   = 5243;
  localparam int RecipMulW  = 13;
  localparam int RecipShift = 19;
  localparam int RecipFullW = ProdW + RecipMulW;
  localparam int QuotW      = RecipFullW - RecipShift;
  localparam logic [ChanW-1:0] ChanMax = '1;

  // Register reset values.
  localparam logic [LevelW-1:0] BrightnessReset = 7'd90;
  localparam logic [LevelW-1:0] FloorReset      = 7'd0;
  localparam logic [LevelW-1:0] CeilingReset    = 7'd100;

  localparam int CfgIdxW = 2;

  typedef enum logic [2:0] {
    MODE_SET_COLOR   = 3'd0,
    MODE_ON          = 3'd1,
    MODE_OFF         = 3'd2,
    MODE_ALL_ON      = 3'd3,
    MODE_BLINK_START = 3'd4,
    MODE_BLINK_STOP  = 3'd5,
    MODE_BLINK_TICK  = 3'd6,
    MODE_REFRESH     = 3'd7
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_FLOOR      = 2'd1,
    CFG_CEILING    = 2'd2
  } cfg_idx_t;

  // These are the step controls for the shared scaling unit.
  typedef struct packed {
    logic mul_en;  // multiply the channel by the level
    logic div_en;  // divide by 100, saturate and shift the byte into the word
  } scale_ctl_t;

endpackage

### rtl/ledmx_scale.sv
// This file holds the shared channel scaling unit: (channel * level) / 100, saturated to a byte.
// Over three channels it builds a 24-bit word. It depends on ledmx_pkg.
`timescale 1ns / 1ps

module ledmx_scale (
  input  logic                             clk,
  input  ledmx_pkg::scale_ctl_t            ctl,
  input  logic [ledmx_pkg::ChanW-1:0]      chan,
  input  logic [ledmx_pkg::LevelW-1:0]     level,
  output logic [ledmx_pkg::ColorW-1:0]     word
);

  logic [ledmx_pkg::ProdW-1:0]      prod_r;
  logic [ledmx_pkg::RecipFullW-1:0] recip_full;
  logic [ledmx_pkg::QuotW-1:0]      quot;
  logic [ledmx_pkg::ChanW-1:0]      sat_byte;
  logic [ledmx_pkg::ColorW-1:0]     word_r;

  // The division by 100 is done as a multiply by its reciprocal. The product is registered first.
  assign recip_full = ledmx_pkg::RecipFullW'(prod_r) *
                      ledmx_pkg::RecipFullW'(ledmx_pkg::RecipMul);
  assign quot       = recip_full[ledmx_pkg::RecipFullW-1:ledmx_pkg::RecipShift];
  assign sat_byte   = (quot > ledmx_pkg::QuotW'(ledmx_pkg::ChanMax)) ?
                      ledmx_pkg::ChanMax : quot[ledmx_pkg::ChanW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= ledmx_pkg::ProdW'(chan) * ledmx_pkg::ProdW'(level);
    end
    if (ctl.div_en) begin
      word_r <= {word_r[ledmx_pkg::ColorW-ledmx_pkg::ChanW-1:0], sat_byte};
    end
  end

  assign word = word_r;

endmodule

### rtl/rgb_led_matrix_frame_encoder.sv
// This is the top level of the LED matrix frame encoder. It holds the pixel store, the command decode
// and the refresh sequencer. It depends on ledmx_pkg and ledmx_scale.
`timescale 1ns / 1ps

// How to use the block
// --------------------
// A command word is taken at a rising edge where start is high and busy is low. in_mode selects
// the command. in_row and in_col address one pixel, and in_red, in_green and in_blue give the
// colour for a set-colour command. A single-pixel command whose address lies outside the matrix
// is ignored.
// Every command except refresh completes at the edge that accepts it. busy stays low, so another
// command can follow in the very next cycle.
// A refresh raises busy and walks the pixels in index order. Each pixel is first read from the
// store, then its green, red and blue channels each take a multiply step and a divide step. All
// three channels go through the one shared multiply and reciprocal-divide unit. busy falls in
// the cycle that carries the final word. Each result word is on out_pixel_index, out_grb_word
// and out_last for exactly one cycle, marked by out_valid. The receiver cannot stall the block
// and must take each word as it comes. The brightness registers are written through cfg_we,
// cfg_index and cfg_wdata. They must be written by the user only while the block is idle; the
// block does not enforce this. The level in use is latched when a refresh is accepted. After
// reset every pixel is black, off and not blinking, and brightness is 90 in the range 0 to 100.
// Colour entries have their own valid bits, so no clearing pass is needed.

module rgb_led_matrix_frame_encoder #(
  parameter int ROW_COUNT = ledmx_pkg::DefaultRows,
  parameter int COL_COUNT = ledmx_pkg::DefaultCols
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_mode,
  input  logic [ledmx_pkg::CoordW-1:0]      in_row,
  input  logic [ledmx_pkg::CoordW-1:0]      in_col,
  input  logic [ledmx_pkg::ChanW-1:0]       in_red,
  input  logic [ledmx_pkg::ChanW-1:0]       in_green,
  input  logic [ledmx_pkg::ChanW-1:0]       in_blue,
  // result channel
  output logic                              out_valid,
  output logic [ledmx_pkg::PixIdxW-1:0]     out_pixel_index,
  output logic [ledmx_pkg::ColorW-1:0]      out_grb_word,
  output logic                              out_last,
  // configuration port
  input  logic                              cfg_we,
  input  logic [ledmx_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ledmx_pkg::LevelW-1:0]      cfg_wdata
);

  localparam int PixTotal = ROW_COUNT * COL_COUNT;
  localparam logic [ledmx_pkg::PixIdxW-1:0] LastIdx = ledmx_pkg::PixIdxW'(PixTotal - 1);
  // These are the on-flag positions that exist in the active matrix.
  localparam logic [ledmx_pkg::PixDepth-1:0] ActiveMask =
    {ledmx_pkg::PixDepth{1'b1}} >> (ledmx_pkg::PixDepth - PixTotal);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV
  } state_t;

  state_t                              state_r;
  logic [ledmx_pkg::PixIdxW-1:0]       idx_r;
  logic [1:0]                          ch_r;
  logic [ledmx_pkg::LevelW-1:0]        level_r;
  logic                                out_valid_r;
  logic [ledmx_pkg::PixIdxW-1:0]       out_idx_r;
  logic                                out_last_r;

  logic [ledmx_pkg::PixDepth-1:0]      on_r;
  logic [ledmx_pkg::PixDepth-1:0]      blink_r;
  logic [ledmx_pkg::PixDepth-1:0]      color_vld_r;

  logic [ledmx_pkg::ColorW-1:0]        color_mem [ledmx_pkg::PixDepth];
  logic [ledmx_pkg::ColorW-1:0]        rd_color_r;
  logic                                rd_live_r;

  logic [ledmx_pkg::LevelW-1:0]        brightness_r;
  logic [ledmx_pkg::LevelW-1:0]        floor_r;
  logic [ledmx_pkg::LevelW-1:0]        ceiling_r;

  logic                                cmd_go;
  ledmx_pkg::mode_t                    cmd_mode;
  logic                                addr_ok;
  logic [ledmx_pkg::PixIdxW-1:0]       cmd_idx;
  logic [ledmx_pkg::LevelW-1:0]        level_nxt;
  logic [ledmx_pkg::ChanW-1:0]         chan_sel;
  ledmx_pkg::scale_ctl_t               scale_ctl;
  logic [ledmx_pkg::ColorW-1:0]        scale_word;

  assign busy     = (state_r != S_IDLE);
  assign cmd_go   = start && !busy;
  assign cmd_mode = ledmx_pkg::mode_t'(in_mode);

  // The pixel address is checked against the matrix size, not against the store depth.
  assign addr_ok = ({1'b0, in_row} < (ledmx_pkg::CoordW + 1)'(ROW_COUNT)) &&
                   ({1'b0, in_col} < (ledmx_pkg::CoordW + 1)'(COL_COUNT));
  assign cmd_idx = ledmx_pkg::PixIdxW'(in_row) * ledmx_pkg::PixIdxW'(COL_COUNT) +
                   ledmx_pkg::PixIdxW'(in_col);

  // The ceiling is tested first; a floor above the ceiling wins unless brightness exceeds the ceiling.
  always_comb begin
    if (brightness_r > ceiling_r) begin
      level_nxt = ceiling_r;
    end else if (brightness_r <= floor_r) begin
      level_nxt = floor_r;
    end else begin
      level_nxt = brightness_r;
    end
  end

  // Channels go green, red, blue, so the shifted word ends up in GRB order. A pixel that is off, or
  // whose colour was never written, feeds zeros and so scales to zero.
  always_comb begin
    case (ch_r)
      2'd0:    chan_sel = rd_color_r[15:8];
      2'd1:    chan_sel = rd_color_r[23:16];
      default: chan_sel = rd_color_r[7:0];
    endcase
    if (!rd_live_r) begin
      chan_sel = '0;
    end
  end

  assign scale_ctl.mul_en = (state_r == S_MUL);
  assign scale_ctl.div_en = (state_r == S_DIV);

  ledmx_scale u_scale (
    .clk   (clk),
    .ctl   (scale_ctl),
    .chan  (chan_sel),
    .level (level_r),
    .word  (scale_word)
  );

  // The colour store has one write port for set-colour and one registered read port for refresh.
  always_ff @(posedge clk) begin
    if (cmd_go && (cmd_mode == ledmx_pkg::MODE_SET_COLOR) && addr_ok) begin
      color_mem[cmd_idx] <= {in_red, in_green, in_blue};
    end
    if (state_r == S_READ) begin
      rd_color_r <= color_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= ledmx_pkg::BrightnessReset;
      floor_r      <= ledmx_pkg::FloorReset;
      ceiling_r    <= ledmx_pkg::CeilingReset;
    end else if (cfg_we) begin
      case (ledmx_pkg::cfg_idx_t'(cfg_index))
        ledmx_pkg::CFG_BRIGHTNESS: brightness_r <= cfg_wdata;
        ledmx_pkg::CFG_FLOOR:      floor_r      <= cfg_wdata;
        ledmx_pkg::CFG_CEILING:    ceiling_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // This block holds the command decode and the refresh sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      ch_r        <= '0;
      level_r     <= '0;
      rd_live_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      out_last_r  <= 1'b0;
      on_r        <= '0;
      blink_r     <= '0;
      color_vld_r <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_go) begin
            case (cmd_mode)
              ledmx_pkg::MODE_SET_COLOR: begin
                if (addr_ok) begin
                  color_vld_r[cmd_idx] <= 1'b1;
                end
              end
              ledmx_pkg::MODE_ON: begin
                if (addr_ok) begin
                  on_r[cmd_idx] <= 1'b1;
                end
              end
              ledmx_pkg::MODE_OFF: begin
                if (addr_ok) begin
                  on_r[cmd_idx] <= 1'b0;
                end
              end
              ledmx_pkg::MODE_ALL_ON: begin
                on_r <= on_r | ActiveMask;
              end
              ledmx_pkg::MODE_BLINK_START: begin
                if (addr_ok) begin
                  on_r[cmd_idx]    <= 1'b1;
                  blink_r[cmd_idx] <= 1'b1;
                end
              end
              ledmx_pkg::MODE_BLINK_STOP: begin
                if (addr_ok) begin
                  on_r[cmd_idx]    <= 1'b0;
                  blink_r[cmd_idx] <= 1'b0;
                end
              end
              ledmx_pkg::MODE_BLINK_TICK: begin
                on_r <= on_r ^ blink_r;
              end
              ledmx_pkg::MODE_REFRESH: begin
                level_r <= level_nxt;
                idx_r   <= '0;
                state_r <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          rd_live_r <= on_r[idx_r] && color_vld_r[idx_r];
          ch_r      <= '0;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (ch_r == 2'd2) begin
            // The third byte lands in the word at this edge, and the word is shown for one cycle.
            out_valid_r <= 1'b1;
            out_idx_r   <= idx_r;
            out_last_r  <= (idx_r == LastIdx);
            idx_r       <= idx_r + ledmx_pkg::PixIdxW'(1);
            state_r     <= (idx_r == LastIdx) ? S_IDLE : S_READ;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_grb_word    = scale_word;
  assign out_last        = out_last_r;

  // The final word of a frame arrives as the sequencer goes idle, and every other word arrives mid-frame.
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("last word shown while the sequencer is still running");

  a_mid_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("mid-frame word shown while idle");

  // A store read always separates two words, so two strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_refresh_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == ledmx_pkg::MODE_REFRESH)) |=> busy)
    else $error("accepted refresh did not start the sequencer");

endmodule

### dv/rgb_led_matrix_frame_encoder_check.sv
// Checker for the LED matrix frame encoder. It keeps its own copy of the pixel store and the
// brightness registers, predicts every refresh frame and compares it with the block's words.
// It depends on ledmx_pkg for the geometry, the command codes and the register indexes.
`timescale 1ns / 1ps

module rgb_led_matrix_frame_encoder_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    in_mode,
  input  logic [ledmx_pkg::CoordW-1:0]  in_row,
  input  logic [ledmx_pkg::CoordW-1:0]  in_col,
  input  logic [ledmx_pkg::ChanW-1:0]   in_red,
  input  logic [ledmx_pkg::ChanW-1:0]   in_green,
  input  logic [ledmx_pkg::ChanW-1:0]   in_blue,
  input  logic                          out_valid,
  input  logic [ledmx_pkg::PixIdxW-1:0] out_pixel_index,
  input  logic [ledmx_pkg::ColorW-1:0]  out_grb_word,
  input  logic                          out_last,
  input  logic                          cfg_we,
  input  logic [ledmx_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ledmx_pkg::LevelW-1:0]  cfg_wdata,
  output int                            fail_count,
  output int                            words_waiting,
  output int                            words_checked
);
  import ledmx_pkg::*;

  localparam int PixTotal = DefaultRows * DefaultCols;

  typedef struct packed {
    logic [PixIdxW-1:0] pix_index;
    logic [ColorW-1:0]  grb;
    logic               last;
  } led_word_t;

  led_word_t         frame_q [$];
  logic [ColorW-1:0] colour_store [PixDepth];
  logic              lit [PixDepth];
  logic              blinking [PixDepth];
  logic [LevelW-1:0] level_req;
  logic [LevelW-1:0] level_floor;
  logic [LevelW-1:0] level_ceil;

  // The ceiling is tested first, so a floor above the ceiling wins only if level_req is within it.
  function automatic logic [LevelW-1:0] level_in_use();
    if (level_req > level_ceil) return level_ceil;
    if (level_req <= level_floor) return level_floor;
    return level_req;
  endfunction

  function automatic logic [ChanW-1:0] scaled(logic [ChanW-1:0] chan, logic [LevelW-1:0] lvl);
    int product;
    product = int'(chan) * int'(lvl) / 100;
    return (product > 255) ? ChanMax : product[ChanW-1:0];
  endfunction

  task automatic apply_command();
    int                pix;
    bit                addr_ok;
    led_word_t         w;
    logic [LevelW-1:0] lvl;
    logic [ColorW-1:0] colour;
    addr_ok = (int'(in_row) < DefaultRows) && (int'(in_col) < DefaultCols);
    pix = int'(in_row) * DefaultCols + int'(in_col);
    case (mode_t'(in_mode))
      MODE_SET_COLOR: if (addr_ok) colour_store[pix] = {in_red, in_green, in_blue};
      MODE_ON:        if (addr_ok) lit[pix] = 1'b1;
      MODE_OFF:       if (addr_ok) lit[pix] = 1'b0;
      MODE_ALL_ON:    for (int i = 0; i < PixTotal; i++) lit[i] = 1'b1;
      MODE_BLINK_START: begin
        if (addr_ok) begin
          blinking[pix] = 1'b1;
          lit[pix] = 1'b1;
        end
      end
      MODE_BLINK_STOP: begin
        if (addr_ok) begin
          blinking[pix] = 1'b0;
          lit[pix] = 1'b0;
        end
      end
      MODE_BLINK_TICK: begin
        for (int i = 0; i < PixTotal; i++) if (blinking[i]) lit[i] = !lit[i];
      end
      MODE_REFRESH: begin
        // The level is fixed when the refresh is taken.
        lvl = level_in_use();
        for (int i = 0; i < PixTotal; i++) begin
          colour = colour_store[i];
          w.pix_index = PixIdxW'(i);
          w.grb = lit[i] ? {scaled(colour[15:8], lvl), scaled(colour[23:16], lvl),
                            scaled(colour[7:0], lvl)} : '0;
          w.last = (i == PixTotal - 1);
          frame_q.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    led_word_t want;
    if (frame_q.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected frame word: index %0d grb %06h last %0b",
                 out_pixel_index, out_grb_word, out_last);
      fail_count++;
    end else begin
      want = frame_q.pop_front();
      words_checked++;
      if (want.pix_index !== out_pixel_index || want.grb !== out_grb_word ||
          want.last !== out_last) begin
        if (fail_count < 10)
          $display("frame word mismatch: expected index %0d grb %06h last %0b, got %0d %06h %0b",
                   want.pix_index, want.grb, want.last, out_pixel_index, out_grb_word, out_last);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PixDepth; i++) begin
        colour_store[i] = '0;
        lit[i] = 1'b0;
        blinking[i] = 1'b0;
      end
      level_req = BrightnessReset;
      level_floor = FloorReset;
      level_ceil = CeilingReset;
      frame_q.delete();
    end else begin
      if (out_valid) check_word();
      if (cfg_we) begin
        case (cfg_index)
          CFG_BRIGHTNESS: level_req = cfg_wdata;
          CFG_FLOOR:      level_floor = cfg_wdata;
          CFG_CEILING:    level_ceil = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) apply_command();
    end
    words_waiting = frame_q.size();
  end

endmodule

### dv/rgb_led_matrix_frame_encoder_test.sv
// Top level of the LED matrix frame encoder testbench: clock, reset, command stimulus,
// brightness set-up and the final verdict. It depends on ledmx_pkg, the encoder itself and
// rgb_led_matrix_frame_encoder_check, which does all the prediction and comparison.
`timescale 1ns / 1ps

module rgb_led_matrix_frame_encoder_test;
  import ledmx_pkg::*;

  // Even a run of nothing but refreshes with the longest gaps stays far below this limit.
  localparam int CycleLimit   = 600000;
  localparam int PhaseCount   = 9;
  localparam int PhaseWords   = 22;
  localparam int FixedPhases  = 7;
  localparam int SettleCycles = 20;
  // Index 3 names no register; writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // Brightness settings for the opening phases: full scale, zero, saturation above 100, the
  // ceiling clamp, the floor clamp, a floor above the ceiling and a floor that saturates.
  int fixed_req   [FixedPhases] = '{100, 0,   127, 127, 50, 50, 0};
  int fixed_floor [FixedPhases] = '{0,   0,   0,   0,   60, 80, 127};
  int fixed_ceil  [FixedPhases] = '{100, 100, 127, 100, 100, 40, 0};

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [2:0]           in_mode;
  logic [CoordW-1:0]    in_row;
  logic [CoordW-1:0]    in_col;
  logic [ChanW-1:0]     in_red;
  logic [ChanW-1:0]     in_green;
  logic [ChanW-1:0]     in_blue;
  logic                 out_valid;
  logic [PixIdxW-1:0]   out_pixel_index;
  logic [ColorW-1:0]    out_grb_word;
  logic                 out_last;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [LevelW-1:0]    cfg_wdata;

  int   fail_count;
  int   words_waiting;
  int   words_checked;
  int   words_sent;
  int   frames_requested;
  int   settings_used;
  int   cycle_count;
  int   burst_left;
  logic took_word;

  rgb_led_matrix_frame_encoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_grb_word    (out_grb_word),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  rgb_led_matrix_frame_encoder_check frame_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_grb_word    (out_grb_word),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .words_waiting   (words_waiting),
    .words_checked   (words_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The handshake is sampled at the rising edge and read back at the following falling
  // edge, so the stimulus never races the block's own update of busy.
  always @(posedge clk) begin
    took_word <= rst_n && start && !busy;
  end

  // Watchdog: a hung refresh or a lost result word ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles with %0d words still expected", cycle_count,
               words_waiting);
      $display("rgb_led_matrix_frame_encoder_test: errors");
      $finish;
    end
  end

  // Presents one command word from a falling edge and holds it until the block takes it.
  // start is left high, so the caller decides whether the next word follows at once.
  task automatic send_word(mode_t m, logic [CoordW-1:0] r, logic [CoordW-1:0] c,
                           logic [ChanW-1:0] red, logic [ChanW-1:0] green,
                           logic [ChanW-1:0] blue);
    start    <= 1'b1;
    in_mode  <= m;
    in_row   <= r;
    in_col   <= c;
    in_red   <= red;
    in_green <= green;
    in_blue  <= blue;
    forever begin
      @(negedge clk);
      if (took_word) break;
    end
    words_sent++;
    if (m == MODE_REFRESH) frames_requested++;
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Waits until every predicted frame word has arrived, then gives the block a few more
  // cycles so that a stray extra word would still be seen before anything else happens.
  task automatic drain();
    start <= 1'b0;
    while (words_waiting != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Writes all three brightness registers, then the unused index with random data.
  // Only called while the block is idle.
  task automatic write_levels(logic [LevelW-1:0] req, logic [LevelW-1:0] floor_v,
                              logic [LevelW-1:0] ceil_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BRIGHTNESS;
    cfg_wdata <= req;
    @(negedge clk);
    cfg_index <= CFG_FLOOR;
    cfg_wdata <= floor_v;
    @(negedge clk);
    cfg_index <= CFG_CEILING;
    cfg_wdata <= ceil_v;
    @(negedge clk);
    cfg_index <= CfgUnused;
    cfg_wdata <= LevelW'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Colour channels lean towards the extremes, where scaling and saturation bite hardest.
  function automatic logic [ChanW-1:0] pick_chan();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ChanMax;
      default: return ChanW'($urandom);
    endcase
  endfunction

  // Set-colour and on commands dominate so that refreshes show plenty of lit pixels, while
  // blink commands and ticks are frequent enough to flip pixels between frames.
  task automatic send_random_word();
    int    pick;
    mode_t m;
    pick = $urandom_range(0, 99);
    if (pick < 25)      m = MODE_SET_COLOR;
    else if (pick < 40) m = MODE_ON;
    else if (pick < 50) m = MODE_OFF;
    else if (pick < 54) m = MODE_ALL_ON;
    else if (pick < 64) m = MODE_BLINK_START;
    else if (pick < 71) m = MODE_BLINK_STOP;
    else if (pick < 82) m = MODE_BLINK_TICK;
    else                m = MODE_REFRESH;
    send_word(m, CoordW'($urandom_range(0, 7)), CoordW'($urandom_range(0, 7)),
              pick_chan(), pick_chan(), pick_chan());
  endtask

  // The sender works in bursts of random length separated by random gaps; in a steady phase
  // it never lets go of start, so words follow back to back, refreshes included.
  task automatic run_random(int count, bit steady);
    for (int k = 0; k < count; k++) begin
      if (!steady && burst_left == 0) begin
        pause($urandom_range(1, 12));
        burst_left = $urandom_range(1, 16);
      end
      send_random_word();
      if (burst_left > 0) burst_left--;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_mode   = MODE_SET_COLOR;
    in_row    = '0;
    in_col    = '0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BRIGHTNESS;
    cfg_wdata = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset brightness of 90. The first refresh shows the cleared
    // store; then the corner pixels get full white and odd bit patterns, all-on lights the
    // black remainder, and the blink commands and ticks toggle pixels between frames.
    send_word(MODE_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_SET_COLOR, 3'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF);
    send_word(MODE_SET_COLOR, 3'd7, 3'd7, 8'h01, 8'h80, 8'hFE);
    send_word(MODE_SET_COLOR, 3'd3, 3'd5, 8'hAA, 8'h55, 8'h0F);
    send_word(MODE_ON, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_ON, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    send_word(MODE_REFRESH, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    send_word(MODE_ALL_ON, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_OFF, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_BLINK_START, 3'd3, 3'd5, 8'h00, 8'h00, 8'h00);
    send_word(MODE_BLINK_START, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_BLINK_START, 3'd0, 3'd7, 8'h00, 8'h00, 8'h00);
    send_word(MODE_BLINK_STOP, 3'd7, 3'd7, 8'h00, 8'h00, 8'h00);
    send_word(MODE_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_BLINK_TICK, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_BLINK_TICK, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_word(MODE_SET_COLOR, 3'd0, 3'd7, 8'hFF, 8'h00, 8'h7F);
    send_word(MODE_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    drain();

    // Random phases, each under its own brightness setting. Every phase ends with the
    // sender holding off until the last frame word has arrived, so that the registers are
    // only ever written while the block is idle.
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < FixedPhases)
        write_levels(LevelW'(fixed_req[p]), LevelW'(fixed_floor[p]), LevelW'(fixed_ceil[p]));
      else
        write_levels(LevelW'($urandom_range(0, 127)), LevelW'($urandom_range(0, 127)),
                     LevelW'($urandom_range(0, 127)));
      run_random(PhaseWords, (p % 4) == 2);
      drain();
    end

    $display("Covered %0d command words, %0d of them frame refreshes, under %0d brightness",
             words_sent, frames_requested, settings_used + 1);
    $display("settings; %0d result words were compared with the predicted frames.",
             words_checked);
    if (fail_count == 0) begin
      $display("rgb_led_matrix_frame_encoder_test: clean");
    end else begin
      $display("%0d failures in total", fail_count);
      $display("rgb_led_matrix_frame_encoder_test: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ledmx_pkg.sv
rtl/ledmx_scale.sv
rtl/rgb_led_matrix_frame_encoder.sv
dv/rgb_led_matrix_frame_encoder_check.sv
dv/rgb_led_matrix_frame_encoder_test.sv
